// File: design/ifpd_pkg.sv
// Shared types, codes and helpers for the indexed frame store with palette.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ifpd_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ARGB_W  = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [ARGB_W-1:0]         argb_t;
  typedef logic [3*COLOR_W-1:0]      rgb_t;

  localparam color_t ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    ACT_PAL8  = 3'd0,
    ACT_PAL6  = 3'd1,
    ACT_PLOT  = 3'd2,
    ACT_FILL  = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PAL,
    ST_CLIP,
    ST_BASE,
    ST_FILL,
    ST_RDF,
    ST_RDP,
    ST_RES
  } state_t;

  // Widens a six-bit component to eight bits by repeating its top two bits.
  function automatic color_t widen6(input color_t c);
    return {c[5:0], c[5:4]};
  endfunction

endpackage

`default_nettype wire

// File: design/ifpd_frame_mem.sv
// Single-port indexed frame store memory with registered read data.
// Depends on ifpd_pkg for the pixel index type.
`default_nettype none

module ifpd_frame_mem #(
  parameter int unsigned DEPTH = 64000,
  parameter int unsigned AW    = 16
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   addr,
  input  wire ifpd_pkg::color_t wdata,
  output ifpd_pkg::color_t     rd_data
);
  import ifpd_pkg::*;

  color_t mem [DEPTH];
  color_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/ifpd_pal_mem.sv
// Palette memory: one write port and one read port, registered read data.
// Depends on ifpd_pkg for the RGB entry type.
`default_nettype none

module ifpd_pal_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned PW    = 8
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [PW-1:0]  waddr,
  input  wire ifpd_pkg::rgb_t wdata,
  input  wire logic [PW-1:0]  raddr,
  output ifpd_pkg::rgb_t      rd_data
);
  import ifpd_pkg::*;

  rgb_t mem [DEPTH];
  rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/ifpd_seq.sv
// Sequencer: clips, steps the shared address adder over covered pixels,
// runs the post-reset clearing pass and holds the result register. Uses ifpd_pkg.
`default_nettype none

module ifpd_seq #(
  parameter int unsigned SCREEN_COLS     = 320,
  parameter int unsigned SCREEN_ROWS     = 200,
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned AW              = 16,
  parameter int unsigned PW              = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_action,
  input  wire ifpd_pkg::color_t in_palette_index,
  input  wire ifpd_pkg::color_t in_red,
  input  wire ifpd_pkg::color_t in_green,
  input  wire ifpd_pkg::color_t in_blue,
  input  wire ifpd_pkg::coord_t in_pos_x,
  input  wire ifpd_pkg::coord_t in_pos_y,
  input  wire ifpd_pkg::coord_t in_rect_width,
  input  wire ifpd_pkg::coord_t in_rect_height,
  input  wire ifpd_pkg::color_t in_color_index,
  output logic                  fm_we,
  output logic [AW-1:0]         fm_addr,
  output ifpd_pkg::color_t      fm_wdata,
  input  wire ifpd_pkg::color_t fm_rdata,
  output logic                  pm_we,
  output logic [PW-1:0]         pm_waddr,
  output ifpd_pkg::rgb_t        pm_wdata,
  output logic [PW-1:0]         pm_raddr,
  input  wire ifpd_pkg::rgb_t   pm_rdata,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ifpd_pkg::argb_t       out_pixel_argb,
  output logic                  out_in_range
);
  import ifpd_pkg::*;

  localparam int unsigned PIXELS   = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned INIT_LEN = (PIXELS > PALETTE_ENTRIES) ? PIXELS : PALETTE_ENTRIES;
  localparam int unsigned IW       = $clog2(INIT_LEN);
  localparam int unsigned CW       = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int unsigned RW       = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  localparam logic [IW:0]         PIX_L   = (IW+1)'(PIXELS);
  localparam logic [IW:0]         ENT_L   = (IW+1)'(PALETTE_ENTRIES);
  localparam logic [IW-1:0]       INIT_LAST = IW'(INIT_LEN - 1);
  localparam logic [8:0]          ENT9    = 9'(PALETTE_ENTRIES);
  localparam logic [AW-1:0]       COLS_A  = AW'(SCREEN_COLS);
  localparam logic [AW:0]         PIX_A   = (AW+1)'(PIXELS);
  localparam logic signed [16:0]  COLS_S  = 17'(SCREEN_COLS);
  localparam logic signed [16:0]  ROWS_S  = 17'(SCREEN_ROWS);
  localparam coord_t              COLS_C  = COORD_W'(SCREEN_COLS);
  localparam coord_t              ROWS_C  = COORD_W'(SCREEN_ROWS);
  localparam coord_t              ONE_C   = 16'sd1;

  state_t          state_r, state_nxt;
  action_t         act_r, act_nxt;
  color_t          pidx_r, pidx_nxt;
  rgb_t            rgb_r, rgb_nxt;
  coord_t          px_r, px_nxt, py_r, py_nxt, w_r, w_nxt, h_r, h_nxt;
  color_t          ci_r, ci_nxt;
  logic [CW-1:0]   x0_r, x0_nxt, xl_r, xl_nxt, col_r, col_nxt;
  logic [RW-1:0]   y0_r, y0_nxt, yl_r, yl_nxt, row_r, row_nxt;
  logic [AW-1:0]   addr_r, addr_nxt, rowb_r, rowb_nxt;
  logic            hit_r, hit_nxt;
  logic            idx_ok_r, idx_ok_nxt;
  logic [IW-1:0]   init_cnt_r, init_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  argb_t           out_argb_r, out_argb_nxt;
  logic            out_in_range_r, out_in_range_nxt;

  logic            accept;
  logic            out_free;
  logic signed [16:0] xe, ye, x0s, y0s, x1s, y1s, xls, yls;
  logic            clip_empty;
  logic [AW-1:0]   base_row;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Clip unit: one signed add per axis and the bound compares.
  assign xe  = {px_r[15], px_r} + {w_r[15], w_r};
  assign ye  = {py_r[15], py_r} + {h_r[15], h_r};
  assign x0s = px_r[15] ? 17'sd0 : {1'b0, px_r};
  assign y0s = py_r[15] ? 17'sd0 : {1'b0, py_r};
  assign x1s = (xe > COLS_S) ? COLS_S : xe;
  assign y1s = (ye > ROWS_S) ? ROWS_S : ye;
  assign xls = x1s - 17'sd1;
  assign yls = y1s - 17'sd1;
  assign clip_empty = (w_r <= 16'sd0) || (h_r <= 16'sd0) || (x0s >= x1s) || (y0s >= y1s);

  assign base_row = AW'(AW'(y0_r) * COLS_A);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (init_cnt_r == INIT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_PAL8, ACT_PAL6: state_nxt = ST_PAL;
            ACT_PLOT, ACT_FILL, ACT_CLEAR, ACT_READ: state_nxt = ST_CLIP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PAL:  state_nxt = ST_IDLE;
      ST_CLIP: begin
        if (!clip_empty) begin
          state_nxt = ST_BASE;
        end else if (act_r == ACT_READ) begin
          state_nxt = ST_RES;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BASE: state_nxt = (act_r == ACT_READ) ? ST_RDF : ST_FILL;
      ST_FILL: begin
        if ((col_r == xl_r) && (row_r == yl_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDF:  state_nxt = ST_RDP;
      ST_RDP:  state_nxt = ST_RES;
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    act_nxt          = act_r;
    pidx_nxt         = pidx_r;
    rgb_nxt          = rgb_r;
    px_nxt           = px_r;
    py_nxt           = py_r;
    w_nxt            = w_r;
    h_nxt            = h_r;
    ci_nxt           = ci_r;
    x0_nxt           = x0_r;
    xl_nxt           = xl_r;
    y0_nxt           = y0_r;
    yl_nxt           = yl_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    addr_nxt         = addr_r;
    rowb_nxt         = rowb_r;
    hit_nxt          = hit_r;
    idx_ok_nxt       = idx_ok_r;
    init_cnt_nxt     = init_cnt_r;
    out_argb_nxt     = out_argb_r;
    out_in_range_nxt = out_in_range_r;
    out_valid_nxt    = out_valid_r && out_stall;

    fm_we    = 1'b0;
    fm_addr  = addr_r;
    fm_wdata = ci_r;
    pm_we    = 1'b0;
    pm_waddr = pidx_r[PW-1:0];
    pm_wdata = rgb_r;
    pm_raddr = fm_rdata[PW-1:0];
    in_ready = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        fm_addr      = init_cnt_r[AW-1:0];
        fm_wdata     = '0;
        fm_we        = {1'b0, init_cnt_r} < PIX_L;
        pm_waddr     = init_cnt_r[PW-1:0];
        pm_wdata     = {3{8'(init_cnt_r[PW-1:0])}};
        pm_we        = {1'b0, init_cnt_r} < ENT_L;
        init_cnt_nxt = init_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          act_nxt  = action_t'(in_action);
          pidx_nxt = in_palette_index;
          ci_nxt   = in_color_index;
          if (action_t'(in_action) == ACT_PAL6) begin
            rgb_nxt = {widen6(in_red), widen6(in_green), widen6(in_blue)};
          end else begin
            rgb_nxt = {in_red, in_green, in_blue};
          end
          px_nxt = in_pos_x;
          py_nxt = in_pos_y;
          w_nxt  = ONE_C;
          h_nxt  = ONE_C;
          if (action_t'(in_action) == ACT_FILL) begin
            w_nxt = in_rect_width;
            h_nxt = in_rect_height;
          end else if (action_t'(in_action) == ACT_CLEAR) begin
            px_nxt = '0;
            py_nxt = '0;
            w_nxt  = COLS_C;
            h_nxt  = ROWS_C;
          end
        end
      end
      ST_PAL: begin
        pm_we = {1'b0, pidx_r} < ENT9;
      end
      ST_CLIP: begin
        hit_nxt = !clip_empty;
        x0_nxt  = x0s[CW-1:0];
        xl_nxt  = xls[CW-1:0];
        y0_nxt  = y0s[RW-1:0];
        yl_nxt  = yls[RW-1:0];
      end
      ST_BASE: begin
        rowb_nxt = base_row;
        addr_nxt = base_row + AW'(x0_r);
        col_nxt  = x0_r;
        row_nxt  = y0_r;
      end
      ST_FILL: begin
        fm_we = 1'b1;
        if (col_r == xl_r) begin
          col_nxt  = x0_r;
          row_nxt  = row_r + 1'b1;
          rowb_nxt = rowb_r + COLS_A;
          addr_nxt = rowb_r + COLS_A + AW'(x0_r);
        end else begin
          col_nxt  = col_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_RDF: begin
      end
      ST_RDP: begin
        idx_ok_nxt = {1'b0, fm_rdata} < ENT9;
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_in_range_nxt = hit_r;
          if (!hit_r) begin
            out_argb_nxt = '0;
          end else if (idx_ok_r) begin
            out_argb_nxt = {ALPHA_OPAQUE, pm_rdata};
          end else begin
            out_argb_nxt = {ALPHA_OPAQUE, 24'h0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r          <= act_nxt;
    pidx_r         <= pidx_nxt;
    rgb_r          <= rgb_nxt;
    px_r           <= px_nxt;
    py_r           <= py_nxt;
    w_r            <= w_nxt;
    h_r            <= h_nxt;
    ci_r           <= ci_nxt;
    x0_r           <= x0_nxt;
    xl_r           <= xl_nxt;
    y0_r           <= y0_nxt;
    yl_r           <= yl_nxt;
    col_r          <= col_nxt;
    row_r          <= row_nxt;
    addr_r         <= addr_nxt;
    rowb_r         <= rowb_nxt;
    hit_r          <= hit_nxt;
    idx_ok_r       <= idx_ok_nxt;
    out_argb_r     <= out_argb_nxt;
    out_in_range_r <= out_in_range_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_argb = out_argb_r;
  assign out_in_range   = out_in_range_r;

  // A fill write must stay inside the frame store and inside the clipped window.
  a_fill_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> ({1'b0, addr_r} < PIX_A))
    else $error("fill address beyond frame store");

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> ((col_r >= x0_r) && (col_r <= xl_r) && (row_r <= yl_r)))
    else $error("fill position outside clipped window");

  // An off-screen read answers all zeros; an on-screen read is always opaque.
  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_in_range_r ? (out_argb_r[31:24] == ALPHA_OPAQUE)
                                    : (out_argb_r == '0)))
    else $error("result color does not match its range flag");

  // A result is only formed after the clip step or the palette lookup.
  a_res_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RES) && ($past(state_r) != ST_RES)) |->
      (($past(state_r) == ST_RDP) || ($past(state_r) == ST_CLIP)))
    else $error("result state entered out of sequence");

endmodule

`default_nettype wire

// File: design/indexed_framebuffer_palette_dac.sv
// Top level of the indexed frame store with palette: ports and memory hookup.
// Depends on ifpd_pkg, ifpd_seq, ifpd_frame_mem and ifpd_pal_mem.
`default_nettype none

// Each transfer is worked off before the next is taken. A rectangle fill or
// clear writes each covered pixel in turn (a clear covers
// SCREEN_COLS*SCREEN_ROWS), a plot, fill or read that covers nothing skips the
// memory steps, and an unused action code is dropped. The single-port frame
// memory writes one pixel per cycle and sets the fill and clear times. After
// reset a clearing pass over max(SCREEN_COLS*SCREEN_ROWS, PALETTE_ENTRIES)
// entries (64000 at the default size) zeroes the frame store and loads the grey
// palette ramp; no input is taken meanwhile. A finished read result waits in an
// output register, so the next input transfer is taken while it is stalled.
module indexed_framebuffer_palette_dac #(
  parameter int unsigned SCREEN_COLS     = 320,
  parameter int unsigned SCREEN_ROWS     = 200,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       in_action,
  input  wire ifpd_pkg::color_t in_palette_index,
  input  wire ifpd_pkg::color_t in_red,
  input  wire ifpd_pkg::color_t in_green,
  input  wire ifpd_pkg::color_t in_blue,
  input  wire ifpd_pkg::coord_t in_pos_x,
  input  wire ifpd_pkg::coord_t in_pos_y,
  input  wire ifpd_pkg::coord_t in_rect_width,
  input  wire ifpd_pkg::coord_t in_rect_height,
  input  wire ifpd_pkg::color_t in_color_index,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ifpd_pkg::argb_t       out_pixel_argb,
  output logic                  out_in_range
);
  import ifpd_pkg::*;

  localparam int unsigned PIXELS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned PW     = $clog2(PALETTE_ENTRIES);

  logic          in_ready;
  logic          fm_we;
  logic [AW-1:0] fm_addr;
  color_t        fm_wdata;
  color_t        fm_rdata;
  logic          pm_we;
  logic [PW-1:0] pm_waddr;
  rgb_t          pm_wdata;
  logic [PW-1:0] pm_raddr;
  rgb_t          pm_rdata;

  assign in_stall = !in_ready;

  ifpd_seq #(
    .SCREEN_COLS     (SCREEN_COLS),
    .SCREEN_ROWS     (SCREEN_ROWS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW),
    .PW              (PW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_palette_index (in_palette_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_color_index   (in_color_index),
    .fm_we            (fm_we),
    .fm_addr          (fm_addr),
    .fm_wdata         (fm_wdata),
    .fm_rdata         (fm_rdata),
    .pm_we            (pm_we),
    .pm_waddr         (pm_waddr),
    .pm_wdata         (pm_wdata),
    .pm_raddr         (pm_raddr),
    .pm_rdata         (pm_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_argb   (out_pixel_argb),
    .out_in_range     (out_in_range)
  );

  ifpd_frame_mem #(
    .DEPTH (PIXELS),
    .AW    (AW)
  ) u_frame_mem (
    .clk     (clk),
    .we      (fm_we),
    .addr    (fm_addr),
    .wdata   (fm_wdata),
    .rd_data (fm_rdata)
  );

  ifpd_pal_mem #(
    .DEPTH (PALETTE_ENTRIES),
    .PW    (PW)
  ) u_pal_mem (
    .clk     (clk),
    .we      (pm_we),
    .waddr   (pm_waddr),
    .wdata   (pm_wdata),
    .raddr   (pm_raddr),
    .rd_data (pm_rdata)
  );

endmodule

`default_nettype wire
